FILE: rtl/dfc_pkg.sv
package dfc_pkg;

   // Direction codes carried by the request opcode
   typedef enum logic [1:0] {
      OP_TO_SINGLE = 2'd0,
      OP_TO_DOUBLE = 2'd1,
      OP_TO_DSP    = 2'd2
   } opcode_type;

   // Exponent biases, narrowed to the field widths they land in
   localparam logic [8:0]  SINGLE_BIAS = 9'd127;
   localparam logic [11:0] DOUBLE_BIAS = 12'd1023;

   // DSP exponent -128, the exponent code of the DSP zero
   localparam logic [7:0] DSP_ZERO_EXP = 8'h80;

   // Low byte of (-1023), used to unbias an IEEE double exponent
   localparam logic [7:0] DOUBLE_UNBIAS_LOW = 8'd1;

   // Biased IEEE double exponent window that maps onto -128..127
   localparam logic [10:0] DOUBLE_EXP_MIN = 11'd895;
   localparam logic [10:0] DOUBLE_EXP_MAX = 11'd1150;

   // Fixed DSP result patterns
   localparam logic [31:0] DSP_ZERO    = 32'h8000_0000;
   localparam logic [31:0] DSP_MAX_POS = 32'h7f7f_ffff;
   localparam logic [31:0] DSP_MAX_NEG = 32'h7f80_0000;

   // Decoded transaction between the decode and pack stages
   typedef struct packed {
      opcode_type  op;
      logic        sgn;
      logic        dsp_zero;
      logic [8:0]  single_exp;
      logic [11:0] double_exp;
      logic [23:0] mag;
      logic        exp_small;
      logic        exp_large;
      logic [7:0]  dsp_exp;
      logic [22:0] dsp_frac;
   } stage_type;

endpackage

FILE: rtl/dfc_if.sv
// Request channel: opcode and 64-bit word
interface dfc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] data_in;

   modport source (output valid, output opcode, output data_in, input ready);
   modport sink (input valid, input opcode, input data_in, output ready);
endinterface

// Response channel: 64-bit converted word
interface dfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink (input valid, input data_out, output ready);
endinterface

FILE: rtl/dfc_decode.sv
module dfc_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic [1:0]         in_opcode,
   input  logic [63:0]        in_data,
   output logic               out_valid,
   output dfc_pkg::stage_type out_stage
);
   import dfc_pkg::*;

   logic [31:0] word;
   logic [7:0]  dsp_e;
   logic [23:0] dsp_m;
   logic [10:0] ieee_e;
   logic [30:0] ieee_m;
   logic [30:0] ieee_m_neg;
   logic        ieee_neg;
   logic        exp_dec;
   stage_type   stage_in;
   stage_type   stage_ff;
   logic        valid_ff;

   assign word       = in_data[31:0];
   assign dsp_e      = word[31:24];
   assign dsp_m      = word[23:0];
   assign ieee_e     = in_data[62:52];
   assign ieee_m     = in_data[51:21];
   assign ieee_neg   = in_data[63];
   assign ieee_m_neg = 31'd0 - ieee_m;
   // Negative with zero fraction is sign only: lower the exponent by one
   assign exp_dec    = ieee_neg && (ieee_m == 31'd0);

   // Unpack both directions; pack stage picks by opcode
   always_comb begin
      stage_in.op         = opcode_type'(in_opcode);
      stage_in.sgn        = (opcode_type'(in_opcode) == OP_TO_DSP) ? ieee_neg : dsp_m[23];
      stage_in.dsp_zero   = (dsp_m == 24'd0) && (dsp_e == DSP_ZERO_EXP);
      stage_in.single_exp = {dsp_e[7], dsp_e} + SINGLE_BIAS;
      stage_in.double_exp = {{4{dsp_e[7]}}, dsp_e} + DOUBLE_BIAS;
      stage_in.mag        = dsp_m[23] ? (24'd0 - dsp_m) : dsp_m;
      stage_in.exp_small  = ieee_e < DOUBLE_EXP_MIN;
      stage_in.exp_large  = ieee_e > DOUBLE_EXP_MAX;
      stage_in.dsp_exp    = ieee_e[7:0] + DOUBLE_UNBIAS_LOW - {7'd0, exp_dec};
      stage_in.dsp_frac   = ieee_neg ? ieee_m_neg[30:8] : ieee_m[30:8];
   end

   // Advance valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

FILE: rtl/dfc_pack.sv
module dfc_pack (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  dfc_pkg::stage_type in_stage,
   output logic               out_valid,
   output logic [63:0]        out_data
);
   import dfc_pkg::*;

   logic [31:0] single_word;
   logic [31:0] double_hi;
   logic [31:0] dsp_word;
   logic [63:0] data_in;
   logic [63:0] data_ff;
   logic        valid_ff;

   // Exponent field plus magnitude; the carry may ripple into the sign bit
   assign single_word = (({in_stage.single_exp, 23'd0} + {8'd0, in_stage.mag})
                        ^ {in_stage.sgn, 31'd0});
   assign double_hi   = (({in_stage.double_exp, 20'd0} + {11'd0, in_stage.mag[23:3]})
                        ^ {in_stage.sgn, 31'd0});

   // Flush small, saturate large, else exponent, sign and fraction
   always_comb begin
      if (in_stage.exp_small) begin
         dsp_word = DSP_ZERO;
      end else if (in_stage.exp_large) begin
         dsp_word = in_stage.sgn ? DSP_MAX_NEG : DSP_MAX_POS;
      end else begin
         dsp_word = {in_stage.dsp_exp, in_stage.sgn, in_stage.dsp_frac};
      end
   end

   // Select result by direction
   always_comb begin
      case (in_stage.op)
         OP_TO_SINGLE: begin
            data_in = in_stage.dsp_zero ? 64'd0 : {32'd0, single_word};
         end
         OP_TO_DOUBLE: begin
            data_in = in_stage.dsp_zero ? 64'd0 : {double_hi, in_stage.mag[2:0], 29'd0};
         end
         OP_TO_DSP: begin
            data_in = {32'd0, dsp_word};
         end
         default: begin
            data_in = 64'd0;
         end
      endcase
   end

   // Advance valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // Hold result until taken
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/dsp_float_ieee_converter.sv
// Converts between the 32-bit DSP float format (signed 8-bit exponent,
// two's complement 24-bit mantissa) and IEEE-754: opcode 0 gives an IEEE
// single in data_out[31:0], opcode 1 an IEEE double, opcode 2 takes an IEEE
// double and gives a DSP word in data_out[31:0]; opcode 3 returns zero. The
// block is a three-stage pipeline (input register, decode register, output
// register): each transaction passes through these registers in turn, and one
// transaction is accepted every cycle unless the response side stalls. A stall
// on the response side fills pipeline bubbles first, then holds the request.
module dsp_float_ieee_converter (
   input logic     clock,
   input logic     reset,
   dfc_req_if.sink req_bus,
   dfc_rsp_if.source rsp_bus
);
   import dfc_pkg::*;

   logic               s1_valid_ff;
   logic [1:0]         s1_opcode_ff;
   logic [63:0]        s1_data_ff;
   logic               s2_valid;
   stage_type          s2_stage;
   logic               en1;
   logic               en2;
   logic               en3;

   // Each stage moves when its successor is empty or moving
   assign en3 = !rsp_bus.valid || rsp_bus.ready;
   assign en2 = !s2_valid || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_bus.ready = en1;

   // Capture transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_opcode_ff <= req_bus.opcode;
         s1_data_ff   <= req_bus.data_in;
      end
   end

   dfc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .enable    (en2),
      .in_valid  (s1_valid_ff),
      .in_opcode (s1_opcode_ff),
      .in_data   (s1_data_ff),
      .out_valid (s2_valid),
      .out_stage (s2_stage)
   );

   dfc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .enable    (en3),
      .in_valid  (s2_valid),
      .in_stage  (s2_stage),
      .out_valid (rsp_bus.valid),
      .out_data  (rsp_bus.data_out)
   );

`ifndef ASSERT_OFF
   // An accepted transaction lands in the input stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> s1_valid_ff)
      else $error("accepted transaction lost at input stage");

   // A blocked input stage holds its transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !en2 |=> s1_valid_ff && $stable(s1_data_ff) && $stable(s1_opcode_ff))
      else $error("input stage changed while blocked");

   // A decoded transaction that moves reaches the output
   a_s2_to_out: assert property (@(posedge clock) disable iff (reset)
      s2_valid && en3 |=> rsp_bus.valid)
      else $error("decoded transaction lost at output stage");

   // A full pipeline with a stalled response refuses new transactions
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid && rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request accepted into a full pipeline");
`endif

endmodule

FILE: verif/tb_dsp_float_ieee_converter.sv
module tb_dsp_float_ieee_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import dfc_pkg::*;

   // Opcode with no conversion behind it; the block answers zero
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // DSP exponent code of the zero word
   localparam logic [7:0] ZERO_EXP_CODE = 8'h80;

   // Biased double exponents at the edges of the DSP range
   localparam int BEXP_LOW  = 895;
   localparam int BEXP_HIGH = 1150;

   localparam int RANDOM_ITEMS = 1830;
   localparam int CALM_ITEMS   = 200;
   localparam int STRETCH      = 120;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;

   // Tracks expected converted words and checks responses in order
   class conv_scoreboard;
      logic [63:0] expected_words[$];
      int errors;
      int checked;
      int op_count[4];

      function new();
         errors = 0;
         checked = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function logic [63:0] dsp_to_single(logic [31:0] w);
         logic [31:0] mant;
         logic [31:0] expo;
         logic [31:0] efield;
         logic [31:0] mag;
         logic [31:0] r;
         mant = w << 8;
         expo = {{24{w[31]}}, w[31:24]};
         if (mant == 32'd0 && w[31:24] == ZERO_EXP_CODE) return 64'd0;
         efield = (expo + 32'd127) << 23;
         if (!mant[31]) begin
            r = efield + (mant >> 8);
         end else begin
            mag = 32'd0 - mant;
            r = 32'h8000_0000 + efield + ((mag >> 8) & 32'h00ff_ffff);
         end
         return {32'd0, r};
      endfunction

      function logic [63:0] dsp_to_double(logic [31:0] w);
         logic [31:0] mant;
         logic [31:0] expo;
         logic [31:0] efield;
         logic [31:0] mag;
         logic [31:0] hi;
         logic [31:0] lo;
         mant = w << 8;
         expo = {{24{w[31]}}, w[31:24]};
         if (mant == 32'd0 && w[31:24] == ZERO_EXP_CODE) return 64'd0;
         efield = (expo + 32'd1023) << 20;
         if (!mant[31]) begin
            hi = efield + (mant >> 11);
            lo = (mant << 21) & 32'hffe0_0000;
         end else begin
            mag = 32'd0 - mant;
            hi = 32'h8000_0000 + efield + ((mag >> 11) & 32'h001f_ffff);
            lo = (mag << 21) & 32'hffe0_0000;
         end
         return {hi, lo};
      endfunction

      function logic [63:0] double_to_dsp(logic [63:0] d);
         logic [31:0] hi;
         logic [31:0] lo;
         logic [31:0] mant;
         logic [31:0] m;
         logic [31:0] e;
         int expo;
         hi = d[63:32];
         lo = d[31:0];
         mant = ((hi & 32'h000f_ffff) << 11) | ((lo & 32'hffe0_0000) >> 21);
         expo = hi[30:20];
         expo = expo - 1023;
         if (expo < -128) begin
            m = 32'd0;
            e = 32'hffff_ff80;
         end else if (expo > 127) begin
            m = hi[31] ? 32'h8000_0001 : 32'h7fff_ffff;
            e = 32'd127;
         end else if (!hi[31]) begin
            m = mant;
            e = expo;
         end else if (mant != 32'd0) begin
            m = 32'h8000_0000 | (32'd0 - mant);
            e = expo;
         end else begin
            // negative power of two: sign-only mantissa, exponent one lower
            m = 32'h8000_0000;
            e = expo - 1;
         end
         return {32'd0, (e << 24) | (m >> 8)};
      endfunction

      function logic [63:0] convert_word(logic [1:0] op, logic [63:0] d);
         case (op)
            OP_TO_SINGLE: return dsp_to_single(d[31:0]);
            OP_TO_DOUBLE: return dsp_to_double(d[31:0]);
            OP_TO_DSP:    return double_to_dsp(d);
            default:      return 64'd0;
         endcase
      endfunction

      function void note_request(logic [1:0] op, logic [63:0] d);
         expected_words.push_back(convert_word(op, d));
         op_count[op]++;
      endfunction

      task check_response(logic [63:0] got);
         logic [63:0] want;
         if (expected_words.size() == 0) begin
            report($sformatf("response %h with nothing outstanding", got));
         end else begin
            want = expected_words.pop_front();
            checked++;
            if (got !== want)
               report($sformatf("data_out %h, expected %h", got, want));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int cycles = 0;
   bit idle_on = 1'b0;
   bit stall_on = 1'b0;
   bit calm = 1'b0;

   dfc_req_if req_bus();
   dfc_rsp_if rsp_bus();

   conv_scoreboard sb = new();

   dsp_float_ieee_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Record accepted requests and check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.opcode, req_bus.data_in);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.data_out);
      end
   end

   // Apply response back-pressure in random bursts
   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (stall_on && !calm && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Drive one transaction, with an optional idle burst ahead of it
   task automatic send_item(logic [1:0] op, logic [63:0] d);
      if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.data_in <= d;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Build a random transaction biased toward the interesting encodings
   task automatic pick_random(output logic [1:0] op, output logic [63:0] d);
      int sel;
      int k;
      logic [10:0] bexp;
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 11);
      d = {$urandom, $urandom};
      if (sel < 30) op = OP_TO_SINGLE;
      else if (sel < 60) op = OP_TO_DOUBLE;
      else if (sel < 96) op = OP_TO_DSP;
      else op = OP_UNUSED;
      if (op == OP_TO_DSP) begin
         if (k < 7) bexp = 11'($urandom_range(BEXP_LOW, BEXP_HIGH));
         else if (k < 9) bexp = 11'($urandom);
         else begin
            case ($urandom_range(0, 5))
               0: bexp = 11'(BEXP_LOW - 1);
               1: bexp = 11'(BEXP_LOW);
               2: bexp = 11'(BEXP_HIGH);
               3: bexp = 11'(BEXP_HIGH + 1);
               4: bexp = 11'h000;
               default: bexp = 11'h7ff;
            endcase
         end
         d[62:52] = bexp;
         // zero the fraction bits that reach the DSP mantissa
         if ($urandom_range(0, 3) == 0) d[51:21] = '0;
      end else if (op != OP_UNUSED) begin
         case (k)
            0: d[31:24] = ZERO_EXP_CODE;
            1: d[22:0] = '0;
            2: d[31:0] = {ZERO_EXP_CODE, 24'd0};
            3: d[31:24] = 8'h7f;
            4: begin
               d[31:24] = ZERO_EXP_CODE;
               d[22:0] = '0;
            end
            default: ;
         endcase
      end
   endtask

   initial begin
      logic [1:0] op;
      logic [63:0] d;
      int i;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_TO_SINGLE;
      req_bus.data_in <= 64'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero, exponent extremes, negative carries, saturation
      send_item(OP_TO_SINGLE, 64'h0000_0000_8000_0000);
      send_item(OP_TO_DOUBLE, 64'hffff_ffff_8000_0000);
      send_item(OP_TO_SINGLE, 64'h0000_0000_8000_0001);
      send_item(OP_TO_DOUBLE, 64'h0000_0000_807f_ffff);
      send_item(OP_TO_SINGLE, 64'h0000_0000_8080_0000);
      send_item(OP_TO_DOUBLE, 64'h0000_0000_8080_0000);
      send_item(OP_TO_SINGLE, 64'h0000_0000_7f7f_ffff);
      send_item(OP_TO_DOUBLE, 64'h1234_5678_7f80_0000);
      send_item(OP_TO_SINGLE, 64'h0000_0000_0000_0000);
      send_item(OP_TO_DOUBLE, 64'h0000_0000_ff80_0000);
      send_item(OP_TO_SINGLE, 64'hdead_beef_00ff_ffff);
      send_item(OP_TO_DOUBLE, 64'h0000_0000_7fff_ffff);
      send_item(OP_TO_DSP, 64'h0000_0000_0000_0000);
      send_item(OP_TO_DSP, 64'h0000_0000_0000_0001);
      send_item(OP_TO_DSP, 64'h7ff0_0000_0000_0000);
      send_item(OP_TO_DSP, 64'hfff8_0000_0000_0001);
      send_item(OP_TO_DSP, 64'h3ff0_0000_0000_0000);
      send_item(OP_TO_DSP, 64'hbff0_0000_0000_0000);
      send_item(OP_TO_DSP, 64'h37f0_0000_0000_0000);
      send_item(OP_TO_DSP, 64'hb7f0_0000_0000_0000);
      send_item(OP_TO_DSP, 64'h37ef_ffff_ffff_ffff);
      send_item(OP_TO_DSP, 64'h47ef_ffff_ffff_ffff);
      send_item(OP_TO_DSP, 64'hc7ef_ffff_ffe0_0000);
      send_item(OP_TO_DSP, 64'hc7f0_0000_0000_0000);
      send_item(OP_UNUSED, 64'hffff_ffff_ffff_ffff);

      // Random: stretches with different idle and stall mixes, then a calm tail
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % STRETCH == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
            stall_on = ($urandom_range(0, 2) != 0);
         end
         if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         pick_random(op, d);
         send_item(op, d);
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_words.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.expected_words.size()));

      $display("covered %0d to-single, %0d to-double, %0d to-dsp, %0d unused-op requests",
               sb.op_count[OP_TO_SINGLE], sb.op_count[OP_TO_DOUBLE],
               sb.op_count[OP_TO_DSP], sb.op_count[OP_UNUSED]);
      $display("%0d responses checked, %0d mismatches, %0d cycles",
               sb.checked, sb.errors, cycles);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
